### hdl/spsfp_pkg.sv
// Shared types, constants and field tables for the H.264 SPS field parser.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package spsfp_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int DEFAULT_MAX_UE_ZEROS = 31;

   localparam logic [4:0] NUM_FIELDS   = 5'd25;
   localparam logic [4:0] STEP_HEADER  = 5'd25;
   localparam logic [4:0] FID_PROFILE  = 5'd0;
   localparam logic [4:0] FID_SPS_ID   = 5'd3;
   localparam logic [4:0] FID_CHROMA   = 5'd4;
   localparam logic [4:0] FID_SCALING  = 5'd8;
   localparam logic [4:0] FID_LOG2_FN  = 5'd9;
   localparam logic [4:0] FID_POC_TYPE = 5'd10;
   localparam logic [4:0] FID_POC_LSB  = 5'd11;
   localparam logic [4:0] FID_MAX_REF  = 5'd12;
   localparam logic [4:0] FID_FRM_MBS  = 5'd16;
   localparam logic [4:0] FID_MB_ADAPT = 5'd17;
   localparam logic [4:0] FID_DIRECT   = 5'd18;
   localparam logic [4:0] FID_CROP     = 5'd19;
   localparam logic [4:0] FID_CROP_L   = 5'd20;
   localparam logic [4:0] FID_VUI      = 5'd24;

   localparam logic KIND_FIELD  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } item_type;

   typedef struct packed {
      logic        kind;
      logic [4:0]  id;
      logic [31:0] value;
      logic [15:0] start;
      logic [5:0]  len;
      logic        inc;
      logic        fin;
   } record_type;

   // Width of a fixed-length field, zero for an Exp-Golomb field.
   function automatic logic [3:0] fixed_width(input logic [4:0] id);
      logic [3:0] w;
      unique case (id) inside
         5'd0, 5'd1, 5'd2: w = 4'd8;
         5'd7, 5'd8, 5'd13, 5'd16, 5'd17, 5'd18, 5'd19, 5'd24: w = 4'd1;
         default: w = 4'd0;
      endcase
      return w;
   endfunction

   function automatic logic is_high(input logic [7:0] p);
      logic h;
      unique case (p) inside
         8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83, 8'd86, 8'd118,
         8'd128, 8'd138, 8'd139, 8'd134, 8'd135: h = 1'b1;
         default: h = 1'b0;
      endcase
      return h;
   endfunction

endpackage

`default_nettype wire

### hdl/spsfp_queue.sv
// Front end of the SPS field parser: accepts byte beats into a short queue.
// Depends on spsfp_pkg.
`default_nettype none

module spsfp_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire  [7:0]            req_data_byte,
   input  wire                   req_last_byte,
   output logic                  q_vld,
   output spsfp_pkg::item_type   q_item,
   input  wire                   q_pop
);
   import spsfp_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;

   assign req_stall = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_vld     = (count_ff != '0);
   assign q_item    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{data: req_data_byte, last: req_last_byte};
      end
   end

endmodule

`default_nettype wire

### hdl/spsfp_engine.sv
// Back end of the SPS field parser: bit-serial field decoder and result register.
// Depends on spsfp_pkg; fed by spsfp_queue.
`default_nettype none

module spsfp_engine #(
   parameter int MAX_UE_ZEROS = spsfp_pkg::DEFAULT_MAX_UE_ZEROS
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   q_vld,
   input  spsfp_pkg::item_type   q_item,
   output logic                  q_pop,
   input  wire                   rsp_stall,
   output logic                  out_vld,
   output spsfp_pkg::record_type out_rec
);
   import spsfp_pkg::*;

   item_type    hold_ff, hold_in;
   logic        hold_vld_ff, hold_vld_in;
   logic [2:0]  bidx_ff, bidx_in;
   logic        end_ff, end_in;

   logic [4:0]  step_ff, step_in;
   logic [15:0] pos_ff, pos_in;
   logic [15:0] fstart_ff, fstart_in;
   logic [5:0]  zrun_ff, zrun_in;
   logic        suffix_ff, suffix_in;
   logic [5:0]  brem_ff, brem_in;
   logic [31:0] acc_ff, acc_in;
   logic        high_ff, high_in;
   logic        fin_ff, fin_in;

   logic        out_vld_ff;
   record_type  out_rec_ff;
   logic        out_free;
   logic        do_bit, do_end;
   logic        rec_vld;
   record_type  rec;

   function automatic logic [4:0] next_field(input logic [4:0] id, input logic [31:0] v,
                                             input logic high);
      logic [4:0] n;
      n = id + 5'd1;
      if (id == FID_SPS_ID) begin
         n = high ? FID_CHROMA : FID_LOG2_FN;
      end else if (id == FID_POC_TYPE) begin
         n = (v == 32'd0) ? FID_POC_LSB : FID_MAX_REF;
      end else if (id == FID_FRM_MBS) begin
         n = (v == 32'd0) ? FID_MB_ADAPT : FID_DIRECT;
      end else if (id == FID_CROP) begin
         n = (v != 32'd0) ? FID_CROP_L : FID_VUI;
      end
      return n;
   endfunction

   assign out_free = !out_vld_ff || !rsp_stall;
   assign do_bit   = hold_vld_ff && out_free;
   assign do_end   = end_ff && out_free;
   assign out_vld  = out_vld_ff;
   assign out_rec  = out_rec_ff;

   always_comb begin
      q_pop       = 1'b0;
      hold_in     = hold_ff;
      hold_vld_in = hold_vld_ff;
      bidx_in     = bidx_ff;
      end_in      = end_ff;
      if (do_bit) begin
         bidx_in = bidx_ff + 3'd1;
         if (bidx_ff == 3'd7) begin
            if (hold_ff.last) begin
               end_in      = 1'b1;
               hold_vld_in = 1'b0;
            end else begin
               q_pop       = q_vld;
               hold_vld_in = q_vld;
               hold_in     = q_item;
            end
         end
      end else if (!hold_vld_ff && (!end_ff || do_end)) begin
         q_pop       = q_vld;
         hold_vld_in = q_vld;
         hold_in     = q_item;
         bidx_in     = 3'd0;
      end
      if (do_end) begin
         end_in = 1'b0;
      end
   end

   always_comb begin
      logic [4:0]  id;
      logic        b;
      logic [15:0] pos_adv;
      logic [5:0]  zrun_new;
      logic [31:0] acc_new;
      logic [5:0]  brem_new;
      logic        cmp;
      logic [31:0] cval;
      logic [5:0]  clen;
      logic        start;
      logic [4:0]  nxt;

      step_in   = step_ff;
      pos_in    = pos_ff;
      fstart_in = fstart_ff;
      zrun_in   = zrun_ff;
      suffix_in = suffix_ff;
      brem_in   = brem_ff;
      acc_in    = acc_ff;
      high_in   = high_ff;
      fin_in    = fin_ff;
      rec_vld   = 1'b0;
      rec       = '0;

      id       = step_ff;
      b        = hold_ff.data[3'd7 - bidx_ff];
      pos_adv  = (pos_ff != 16'hFFFF) ? pos_ff + 16'd1 : pos_ff;
      zrun_new = zrun_ff + 6'd1;
      acc_new  = {acc_ff[30:0], b};
      brem_new = (brem_ff != 6'd0) ? brem_ff - 6'd1 : brem_ff;
      cmp      = 1'b0;
      cval     = '0;
      clen     = '0;
      start    = 1'b0;
      nxt      = FID_PROFILE;

      if (do_bit && !fin_ff) begin
         pos_in = pos_adv;
         if (id >= NUM_FIELDS) begin
            if (pos_adv >= 16'd8) begin
               start = 1'b1;
            end
         end else if (fixed_width(id) != 4'd0) begin
            acc_in  = acc_new;
            brem_in = brem_new;
            if (brem_new == 6'd0) begin
               cmp  = 1'b1;
               cval = acc_new;
               clen = {2'b00, fixed_width(id)};
            end
         end else if (!suffix_ff) begin
            if (!b) begin
               zrun_in = zrun_new;
               if (zrun_new > 6'(MAX_UE_ZEROS)) begin
                  rec_vld    = 1'b1;
                  rec.kind   = KIND_STATUS;
                  rec.id     = id;
                  rec.start  = fstart_ff;
                  rec.inc    = 1'b1;
                  rec.fin    = 1'b1;
                  fin_in     = 1'b1;
               end
            end else if (zrun_ff == 6'd0) begin
               cmp  = 1'b1;
               cval = 32'd0;
               clen = 6'd1;
            end else begin
               suffix_in = 1'b1;
               brem_in   = zrun_ff;
               acc_in    = 32'd1;
            end
         end else begin
            acc_in  = acc_new;
            brem_in = brem_new;
            if (brem_new == 6'd0) begin
               cmp  = 1'b1;
               cval = acc_new - 32'd1;
               clen = {zrun_ff[4:0], 1'b1};
            end
         end
      end

      if (cmp) begin
         rec_vld   = 1'b1;
         rec.kind  = KIND_FIELD;
         rec.id    = id;
         rec.value = cval;
         rec.start = fstart_ff;
         rec.len   = clen;
         if (id == FID_SCALING && cval != 32'd0) begin
            rec.inc = 1'b1;
            rec.fin = 1'b1;
            fin_in  = 1'b1;
         end else if (id == FID_VUI) begin
            rec.fin = 1'b1;
            fin_in  = 1'b1;
         end else begin
            if (id == FID_PROFILE) begin
               high_in = is_high(cval[7:0]);
            end
            nxt   = next_field(id, cval, high_ff);
            start = 1'b1;
         end
      end

      if (start) begin
         step_in   = nxt;
         fstart_in = pos_adv;
         zrun_in   = '0;
         suffix_in = 1'b0;
         acc_in    = '0;
         brem_in   = {2'b00, fixed_width(nxt)};
      end

      if (do_end) begin
         if (!fin_ff) begin
            rec_vld   = 1'b1;
            rec.kind  = KIND_STATUS;
            rec.id    = (step_ff < NUM_FIELDS) ? step_ff : FID_PROFILE;
            rec.start = fstart_ff;
            rec.inc   = 1'b1;
            rec.fin   = 1'b1;
         end
         step_in   = STEP_HEADER;
         pos_in    = '0;
         fstart_in = '0;
         zrun_in   = '0;
         suffix_in = 1'b0;
         brem_in   = '0;
         acc_in    = '0;
         high_in   = 1'b0;
         fin_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
         bidx_ff     <= '0;
         end_ff      <= 1'b0;
         step_ff     <= STEP_HEADER;
         pos_ff      <= '0;
         fstart_ff   <= '0;
         zrun_ff     <= '0;
         suffix_ff   <= 1'b0;
         brem_ff     <= '0;
         acc_ff      <= '0;
         high_ff     <= 1'b0;
         fin_ff      <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         hold_vld_ff <= hold_vld_in;
         bidx_ff     <= bidx_in;
         end_ff      <= end_in;
         step_ff     <= step_in;
         pos_ff      <= pos_in;
         fstart_ff   <= fstart_in;
         zrun_ff     <= zrun_in;
         suffix_ff   <= suffix_in;
         brem_ff     <= brem_in;
         acc_ff      <= acc_in;
         high_ff     <= high_in;
         fin_ff      <= fin_in;
         if (out_free) begin
            out_vld_ff <= rec_vld;
         end
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      if (out_free && rec_vld) begin
         out_rec_ff <= rec;
      end
   end

endmodule

`default_nettype wire

### hdl/h264_sps_field_parser.sv
// Top level of the H.264 SPS field parser: byte queue in front of the bit-serial decoder.
// Depends on spsfp_pkg, spsfp_queue and spsfp_engine.
//
// The block takes an SPS NAL unit one byte per beat, header byte first, and gives one
// record beat for each syntax element it decodes, plus a status beat when the unit is
// cut short or a code is overlong. The decoder consumes one bit per clock cycle while a
// byte is held and the result register is free; after the last byte of each NAL unit an
// end flag is registered, on which the unit is closed and the decoder returns to the
// header state. A two-beat queue holds incoming bytes while the decoder works, and the
// result register holds a record until taken; a stalled result holds the decoder still.
`default_nettype none

module h264_sps_field_parser #(
   parameter int MAX_UE_ZEROS = spsfp_pkg::DEFAULT_MAX_UE_ZEROS
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [7:0]  req_data_byte,
   input  wire         req_last_byte,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic        rsp_record_kind,
   output logic [4:0]  rsp_field_id,
   output logic [31:0] rsp_field_value,
   output logic [15:0] rsp_start_bit,
   output logic [5:0]  rsp_length_bits,
   output logic        rsp_incomplete,
   output logic        rsp_final_record
);
   import spsfp_pkg::*;

   logic       q_vld;
   item_type   q_item;
   logic       q_pop;
   record_type out_rec;

   spsfp_queue u_queue (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_vld         (q_vld),
      .q_item        (q_item),
      .q_pop         (q_pop)
   );

   spsfp_engine #(
      .MAX_UE_ZEROS (MAX_UE_ZEROS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .q_vld     (q_vld),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_stall (rsp_stall),
      .out_vld   (rsp_valid),
      .out_rec   (out_rec)
   );

   assign rsp_record_kind  = out_rec.kind;
   assign rsp_field_id     = out_rec.id;
   assign rsp_field_value  = out_rec.value;
   assign rsp_start_bit    = out_rec.start;
   assign rsp_length_bits  = out_rec.len;
   assign rsp_incomplete   = out_rec.inc;
   assign rsp_final_record = out_rec.fin;

endmodule

`default_nettype wire
